// ===== src/fcat_pkg.sv =====
// Shared types and constants for the fault code aging table.
package fcat_pkg;

  localparam int CODE_W     = 8;
  localparam int TIMER_W    = 8;
  localparam int NUM_LISTS  = 3;
  localparam int NUM_CODES  = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;
  localparam int CAT_W      = 2;
  localparam int SLOT_OUT_W = 4;
  localparam int CNT_OUT_W  = 4;

  localparam logic [TIMER_W-1:0] HOLD_RESET = 8'd12;

  // List codes as reported in the category field
  localparam logic [CAT_W-1:0] LIST_BATTERY = 2'd0;
  localparam logic [CAT_W-1:0] LIST_MOTOR   = 2'd1;
  localparam logic [CAT_W-1:0] LIST_OTHER   = 2'd2;

  // Position of each code within the item, in the order they are applied
  localparam logic [2:0] CIDX_MOTOR   = 3'd0;
  localparam logic [2:0] CIDX_BATTERY = 3'd1;
  localparam logic [2:0] CIDX_LAST    = 3'(NUM_CODES - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SWEEP = 5'b00010,
    ST_APPLY = 5'b00100,
    ST_EREAD = 5'b01000,
    ST_EEMIT = 5'b10000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // latch a new item, rewind the sweep and emission counters
    logic sweep;   // compaction sweep step
    logic apply;   // refresh or insert the current code
    logic eread;   // read the slot to report
    logic emit;    // load the result register, age the slot
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_done;
    logic last_code;
    logic out_free;
    logic emit_last;
  } status_t;

  // List that a code position updates
  function automatic logic [CAT_W-1:0] code_list(input logic [2:0] cidx);
    logic [CAT_W-1:0] lst;
    case (cidx)
      CIDX_MOTOR:   lst = LIST_MOTOR;
      CIDX_BATTERY: lst = LIST_BATTERY;
      default:      lst = LIST_OTHER;
    endcase
    return lst;
  endfunction

endpackage

// ===== src/fault_code_aging_table.sv =====
// Top level of the fault code aging table.
// Three fault lists (battery, motor, other) of SLOTS_PER_LIST slots live in one
// table memory with one read and one write port and a valid bit per slot. An
// item of five codes is applied one code at a time. A sweep compacts the list
// while it looks for a live match, reading one slot per cycle and writing live
// entries back toward the front. An apply step then refreshes or inserts the
// code. All 3*SLOTS_PER_LIST slots are then reported and aged, each in a read
// step and then an emit step that writes it back; the emit step waits while
// the output register holds an untaken result. The next item is taken as soon
// as the last result is in the output register. hold_time may be written only
// while the block is idle.
module fault_code_aging_table #(
  parameter int SLOTS_PER_LIST = 15
) (
  input  logic                                clk,
  input  logic                                rst,
  // motor_code, battery_code, other_code_a, other_code_b, other_code_c
  input  logic [fcat_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // slot[3:0], code[11:4], live[12], live_count[16:13], zero fill
  output logic [fcat_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // category[1:0]
  output logic [fcat_pkg::CAT_W-1:0]          m_axis_tuser,
  output logic                                m_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_wr_en,
  input  logic [fcat_pkg::TIMER_W-1:0]        cfg_wr_data
);

  fcat_pkg::cmd_t    cmd;
  fcat_pkg::status_t status;

  logic [fcat_pkg::SLOT_OUT_W-1:0] out_slot;
  logic [fcat_pkg::CODE_W-1:0]     out_code;
  logic                            out_live;
  logic [fcat_pkg::CNT_OUT_W-1:0]  out_live_count;

  fcat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  fcat_dp #(
    .SLOTS_PER_LIST (SLOTS_PER_LIST)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_data        (s_axis_tdata),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_category   (m_axis_tuser),
    .out_slot       (out_slot),
    .out_code       (out_code),
    .out_live       (out_live),
    .out_live_count (out_live_count),
    .out_last       (m_axis_tlast)
  );

  // Pack result fields, lowest first
  assign m_axis_tdata = {7'd0, out_live_count, out_live, out_code, out_slot};

endmodule

// ===== src/fcat_ctrl.sv =====
// Sequencing state machine for the fault code aging table.
module fcat_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fcat_pkg::status_t  status,
  output fcat_pkg::cmd_t     cmd
);

  fcat_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcat_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == fcat_pkg::ST_IDLE);

  // Commands
  always_comb begin
    cmd        = '0;
    cmd.accept = (state == fcat_pkg::ST_IDLE) && in_valid;
    cmd.sweep  = (state == fcat_pkg::ST_SWEEP);
    cmd.apply  = (state == fcat_pkg::ST_APPLY);
    cmd.eread  = (state == fcat_pkg::ST_EREAD);
    cmd.emit   = (state == fcat_pkg::ST_EEMIT) && status.out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      fcat_pkg::ST_IDLE: begin
        if (in_valid) state_next = fcat_pkg::ST_SWEEP;
      end
      fcat_pkg::ST_SWEEP: begin
        if (status.sweep_done) state_next = fcat_pkg::ST_APPLY;
      end
      fcat_pkg::ST_APPLY: begin
        state_next = status.last_code ? fcat_pkg::ST_EREAD : fcat_pkg::ST_SWEEP;
      end
      fcat_pkg::ST_EREAD: begin
        state_next = fcat_pkg::ST_EEMIT;
      end
      fcat_pkg::ST_EEMIT: begin
        if (status.out_free) begin
          state_next = status.emit_last ? fcat_pkg::ST_IDLE : fcat_pkg::ST_EREAD;
        end
      end
      default: state_next = fcat_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== src/fcat_dp.sv =====
// Slot table, sweep counters and result register for the fault code aging table.
module fcat_dp #(
  parameter int SLOTS_PER_LIST = 15
) (
  input  logic                                clk,
  input  logic                                rst,
  input  fcat_pkg::cmd_t                      cmd,
  output fcat_pkg::status_t                   status,
  input  logic [fcat_pkg::IN_DATA_W-1:0]      in_data,
  input  logic                                cfg_wr_en,
  input  logic [fcat_pkg::TIMER_W-1:0]        cfg_wr_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fcat_pkg::CAT_W-1:0]          out_category,
  output logic [fcat_pkg::SLOT_OUT_W-1:0]     out_slot,
  output logic [fcat_pkg::CODE_W-1:0]         out_code,
  output logic                                out_live,
  output logic [fcat_pkg::CNT_OUT_W-1:0]      out_live_count,
  output logic                                out_last
);

  localparam int N     = SLOTS_PER_LIST;
  localparam int TOTAL = fcat_pkg::NUM_LISTS * N;
  localparam int AW    = $clog2(TOTAL);
  localparam int CW    = $clog2(N + 1);
  localparam int SW    = $clog2(N);
  localparam int EW    = fcat_pkg::CODE_W + fcat_pkg::TIMER_W;

  // Entry layout: code in the high byte, timer in the low byte
  logic [EW-1:0] mem [TOTAL];
  logic [TOTAL-1:0] valid;
  logic [EW-1:0] rdata;
  logic          rbit;

  logic [fcat_pkg::TIMER_W-1:0] hold_time;
  logic [fcat_pkg::CODE_W-1:0]  codes_q [fcat_pkg::NUM_CODES];
  logic [2:0]                   cidx;
  logic [CW-1:0]                rd, wr;
  logic                         pend;
  logic [SW-1:0]                proc_slot;
  logic                         hit;
  logic [SW-1:0]                hit_pos;
  logic [CW-1:0]                lcount [fcat_pkg::NUM_LISTS];
  logic [fcat_pkg::CAT_W-1:0]   elist;
  logic [SW-1:0]                es;

  logic [fcat_pkg::CAT_W-1:0]   cur_list;
  logic [fcat_pkg::CODE_W-1:0]  cur_code;
  logic [AW-1:0]                cur_base, e_base;
  logic                         rlive;
  logic                         rd_en, wr_en, clr_en;
  logic [AW-1:0]                raddr, waddr, caddr;
  logic [EW-1:0]                wdata;
  logic                         sweep_proc, do_ins, do_ref;
  logic [CW-1:0]                cnt_new;
  logic                         emit_last;

  assign cur_list = fcat_pkg::code_list(cidx);
  assign cur_code = codes_q[cidx];
  assign cur_base = AW'(cur_list) * AW'(N);
  assign e_base   = AW'(elist) * AW'(N);
  assign rlive    = rbit && (rdata[fcat_pkg::TIMER_W-1:0] != '0);

  assign sweep_proc = cmd.sweep && pend;
  assign do_ref     = cmd.apply && (cur_code != '0) && hit;
  assign do_ins     = cmd.apply && (cur_code != '0) && !hit && (wr < CW'(N));
  assign emit_last  = (elist == fcat_pkg::LIST_OTHER) && (es == SW'(N - 1));

  // Live count after the update: inserts with a zero hold are dead at once,
  // and a refresh with a zero hold kills the matched slot
  assign cnt_new = wr + CW'(do_ins && (hold_time != '0))
                      - CW'(do_ref && (hold_time == '0));

  // Read port
  always_comb begin
    rd_en = 1'b0;
    raddr = e_base + AW'(es);
    if (cmd.sweep && (rd < CW'(N))) begin
      rd_en = 1'b1;
      raddr = cur_base + AW'(rd);
    end else if (cmd.eread) begin
      rd_en = 1'b1;
    end
  end

  // Write port: sweep move, refresh/insert, or aging
  always_comb begin
    wr_en  = 1'b0;
    waddr  = cur_base + AW'(wr);
    wdata  = rdata;
    clr_en = sweep_proc;
    caddr  = cur_base + AW'(proc_slot);
    if (sweep_proc && rlive) begin
      wr_en = 1'b1;
    end else if (do_ref || do_ins) begin
      wr_en = 1'b1;
      waddr = do_ref ? cur_base + AW'(hit_pos) : cur_base + AW'(wr);
      wdata = {cur_code, hold_time};
    end else if (cmd.emit && rlive) begin
      wr_en = 1'b1;
      waddr = e_base + AW'(es);
      wdata = {rdata[EW-1:fcat_pkg::TIMER_W],
               rdata[fcat_pkg::TIMER_W-1:0] - fcat_pkg::TIMER_W'(1)};
    end
  end

  // Table memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= wdata;
    if (rd_en) rdata <= mem[raddr];
  end

  // Valid bits: a moved entry leaves a dead slot behind; set wins on overlap
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rbit  <= 1'b0;
    end else begin
      if (clr_en) valid[caddr] <= 1'b0;
      if (wr_en)  valid[waddr] <= 1'b1;
      if (rd_en)  rbit <= valid[raddr];
    end
  end

  // Hold time register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time <= fcat_pkg::HOLD_RESET;
    end else if (cfg_wr_en) begin
      hold_time <= cfg_wr_data;
    end
  end

  // Item codes and live counts
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int i = 0; i < fcat_pkg::NUM_CODES; i++) begin
        codes_q[i] <= in_data[i*fcat_pkg::CODE_W +: fcat_pkg::CODE_W];
      end
    end
    if (cmd.apply) lcount[cur_list] <= cnt_new;
  end

  // Sweep and emission counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cidx      <= '0;
      rd        <= '0;
      wr        <= '0;
      pend      <= 1'b0;
      hit       <= 1'b0;
      hit_pos   <= '0;
      proc_slot <= '0;
      elist     <= '0;
      es        <= '0;
    end else if (cmd.accept) begin
      cidx  <= '0;
      rd    <= '0;
      wr    <= '0;
      pend  <= 1'b0;
      hit   <= 1'b0;
      elist <= '0;
      es    <= '0;
    end else if (cmd.sweep) begin
      pend <= rd_en;
      if (rd_en) begin
        rd        <= rd + CW'(1);
        proc_slot <= rd[SW-1:0];
      end
      // live entries close up; remember the first live match
      if (sweep_proc && rlive) begin
        wr <= wr + CW'(1);
        if (!hit && (rdata[EW-1:fcat_pkg::TIMER_W] == cur_code)) begin
          hit     <= 1'b1;
          hit_pos <= wr[SW-1:0];
        end
      end
    end else if (cmd.apply) begin
      cidx <= cidx + 3'd1;
      rd   <= '0;
      wr   <= '0;
      pend <= 1'b0;
      hit  <= 1'b0;
    end else if (cmd.emit) begin
      if (es == SW'(N - 1)) begin
        es    <= '0;
        elist <= elist + fcat_pkg::CAT_W'(1);
      end else begin
        es <= es + SW'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_category   <= elist;
      out_slot       <= fcat_pkg::SLOT_OUT_W'(es);
      out_code       <= rlive ? rdata[EW-1:fcat_pkg::TIMER_W] : '0;
      out_live       <= rlive;
      out_live_count <= fcat_pkg::CNT_OUT_W'(lcount[elist]);
      out_last       <= emit_last;
    end
  end

  // Status
  assign status.sweep_done = (rd == CW'(N)) && !pend;
  assign status.last_code  = (cidx == fcat_pkg::CIDX_LAST);
  assign status.out_free   = !out_valid || out_ready;
  assign status.emit_last  = emit_last;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the fault code aging table: directed and random reports.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = 15;
  localparam int TABLE_SLOTS = fcat_pkg::NUM_LISTS * SLOTS;
  localparam int QUIET_LIMIT = 2000;

  // One report item, motor code in the low byte
  typedef struct packed {
    logic [fcat_pkg::CODE_W-1:0] other_c;
    logic [fcat_pkg::CODE_W-1:0] other_b;
    logic [fcat_pkg::CODE_W-1:0] other_a;
    logic [fcat_pkg::CODE_W-1:0] battery;
    logic [fcat_pkg::CODE_W-1:0] motor;
  } report_t;

  // One reported slot
  typedef struct packed {
    logic [fcat_pkg::CAT_W-1:0]      category;
    logic [fcat_pkg::SLOT_OUT_W-1:0] slot;
    logic [fcat_pkg::CODE_W-1:0]     code;
    logic                            live;
    logic [fcat_pkg::CNT_OUT_W-1:0]  live_count;
    logic                            last;
  } slot_report_t;

  logic                            clk           = 1'b0;
  logic                            rst           = 1'b1;
  logic [fcat_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [fcat_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [fcat_pkg::CAT_W-1:0]      m_axis_tuser;
  logic                            m_axis_tlast;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic                            cfg_wr_en     = 1'b0;
  logic [fcat_pkg::TIMER_W-1:0]    cfg_wr_data   = '0;

  // Predictor state: code and hold timer per slot, plus the hold setting
  logic [fcat_pkg::CODE_W-1:0]  list_code  [TABLE_SLOTS];
  logic [fcat_pkg::TIMER_W-1:0] list_timer [TABLE_SLOTS];
  logic [fcat_pkg::TIMER_W-1:0] hold_q = fcat_pkg::HOLD_RESET;

  slot_report_t pending_slots[$];

  int  errors        = 0;
  int  reports_sent  = 0;
  int  slots_checked = 0;
  int  quiet_cycles  = 0;
  int  rx_hold       = 0;
  bit  steady_tx     = 1'b0;
  bit  steady_rx     = 1'b0;

  fault_code_aging_table #(
    .SLOTS_PER_LIST(SLOTS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    for (int k = 0; k < TABLE_SLOTS; k++) begin
      list_code[k]  = '0;
      list_timer[k] = '0;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Move live slots to the front of a list, keeping their order
  function automatic void squeeze_list(int base);
    int wr;
    wr = 0;
    for (int rd = 0; rd < SLOTS; rd++) begin
      if (list_timer[base+rd] != 0) begin
        list_code[base+wr]  = list_code[base+rd];
        list_timer[base+wr] = list_timer[base+rd];
        wr++;
      end
    end
    for (int k = wr; k < SLOTS; k++) list_timer[base+k] = '0;
  endfunction

  // Compact, then refresh a live match or take the first free slot
  function automatic void post_code(logic [fcat_pkg::CAT_W-1:0] lst,
                                    logic [fcat_pkg::CODE_W-1:0] code);
    int base;
    base = int'(lst) * SLOTS;
    squeeze_list(base);
    if (code == '0) return;
    for (int s = 0; s < SLOTS; s++) begin
      if (list_timer[base+s] != 0 && list_code[base+s] == code) begin
        list_timer[base+s] = hold_q;
        return;
      end
      if (list_timer[base+s] == 0) begin
        list_code[base+s]  = code;
        list_timer[base+s] = hold_q;
        return;
      end
    end
  endfunction

  // Apply one report and queue the slot results it produces, then age
  function automatic void predict_slot_reports(report_t r);
    int base;
    int count;
    slot_report_t e;
    post_code(fcat_pkg::LIST_MOTOR, r.motor);
    post_code(fcat_pkg::LIST_BATTERY, r.battery);
    post_code(fcat_pkg::LIST_OTHER, r.other_a);
    post_code(fcat_pkg::LIST_OTHER, r.other_b);
    post_code(fcat_pkg::LIST_OTHER, r.other_c);
    for (int l = 0; l < fcat_pkg::NUM_LISTS; l++) begin
      base  = l * SLOTS;
      count = 0;
      for (int s = 0; s < SLOTS; s++)
        if (list_timer[base+s] != 0) count++;
      for (int s = 0; s < SLOTS; s++) begin
        e.category   = fcat_pkg::CAT_W'(l);
        e.slot       = fcat_pkg::SLOT_OUT_W'(s);
        e.live       = (list_timer[base+s] != 0);
        e.code       = e.live ? list_code[base+s] : '0;
        e.live_count = fcat_pkg::CNT_OUT_W'(count);
        e.last       = (l == fcat_pkg::NUM_LISTS - 1) && (s == SLOTS - 1);
        if (e.live) list_timer[base+s] = list_timer[base+s] - 1'b1;
        pending_slots.push_back(e);
      end
    end
  endfunction

  // Send one report item; entered and left at a falling edge
  task automatic send_report(report_t r);
    int gap;
    s_axis_tdata  <= r;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_slot_reports(r);
    reports_sent++;
    @(negedge clk);
    gap = steady_tx ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_codes(logic [7:0] motor, logic [7:0] battery,
                            logic [7:0] oa, logic [7:0] ob, logic [7:0] oc);
    report_t r;
    r.motor   = motor;
    r.battery = battery;
    r.other_a = oa;
    r.other_b = ob;
    r.other_c = oc;
    send_report(r);
  endtask

  // Hold off until every slot result is back, then let the block go idle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_slots.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_hold_time(logic [fcat_pkg::TIMER_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    hold_q = value;
  endtask

  // Random code, zero about a third of the time; pool > 0 narrows the range
  function automatic logic [7:0] rand_code(int pool);
    if ($urandom_range(0, 9) < 3) return '0;
    if (pool != 0) return 8'($urandom_range(1, pool));
    return 8'($urandom_range(1, 255));
  endfunction

  // Reset hold time, empty reports and first inserts
  task automatic test_reset_hold();
    send_codes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_codes(8'h01, 8'h80, 8'h00, 8'h00, 8'h00);
  endtask

  // Short hold: expiry in the middle of a list, consecutive dead slots
  task automatic test_compaction();
    set_hold_time(8'd3);
    send_codes(8'h00, 8'h00, 8'h10, 8'h11, 8'h12);
    send_codes(8'h00, 8'h00, 8'h13, 8'h00, 8'h00);
    send_codes(8'h00, 8'h00, 8'h10, 8'h13, 8'h00);
    send_codes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_codes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  // Zero hold: inserts die at once, refreshes kill live slots
  task automatic test_zero_hold();
    set_hold_time(8'd0);
    send_codes(8'h01, 8'h80, 8'h5A, 8'h5A, 8'hA5);
    send_codes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  // Code extremes, refresh, duplicates in one item, and a full other list
  task automatic test_full_lists();
    set_hold_time(8'd20);
    send_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_codes(8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F);
    send_codes(8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F);
    for (int i = 0; i < 4; i++)
      send_codes(8'h00, 8'h00, 8'(8'h20 + 3*i), 8'(8'h21 + 3*i), 8'(8'h22 + 3*i));
    // list is full: refresh still works, a new code is dropped
    send_codes(8'hFE, 8'h7E, 8'h20, 8'hC3, 8'h00);
  endtask

  // Hold of one: a code lives for exactly one report
  task automatic test_min_hold();
    set_hold_time(8'd1);
    send_codes(8'h33, 8'hCC, 8'h0F, 8'hF0, 8'h00);
    send_codes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  // Random reports; optional first half without any idling on either side
  task automatic run_random_reports(int count, int pool, bit steady_half);
    report_t r;
    for (int i = 0; i < count; i++) begin
      steady_tx = steady_half && (i < count / 2);
      steady_rx = steady_tx;
      r.motor   = rand_code(pool);
      r.battery = rand_code(pool);
      r.other_a = rand_code(pool);
      r.other_b = rand_code(pool);
      r.other_c = rand_code(pool);
      if ($urandom_range(0, 7) == 0) r.other_b = r.other_a;
      send_report(r);
    end
    steady_tx = 1'b0;
    steady_rx = 1'b0;
  endtask

  task automatic test_random_short_hold();
    set_hold_time(8'($urandom_range(2, 6)));
    run_random_reports(30, 8, 1'b0);
  endtask

  task automatic test_random_any_hold();
    set_hold_time(8'($urandom_range(1, 255)));
    run_random_reports(24, ($urandom_range(0, 1) != 0) ? 12 : 0, 1'b1);
  endtask

  task automatic test_random_max_hold();
    set_hold_time(8'd255);
    run_random_reports(30, 0, 1'b0);
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    if (rx_hold != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!steady_rx && $urandom_range(0, 5) == 0) rx_hold = pick_gap();
    end
  end

  function automatic void flag_field(string name, slot_report_t ctx,
                                     logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= 100)
        $display("%0t ns: list %0d slot %0d %s expected %0h actual %0h",
                 $time, ctx.category, ctx.slot, name, exp_v, act_v);
    end
  endfunction

  // Result checker
  always @(posedge clk) begin : check_slots
    slot_report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_slots.size() == 0) begin
        errors++;
        if (errors <= 100)
          $display("%0t ns: unexpected item, expected none, actual tdata %0h tuser %0d",
                   $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_slots.pop_front();
        slots_checked++;
        flag_field("category", want, 8'(want.category), 8'(m_axis_tuser));
        flag_field("slot", want, 8'(want.slot), 8'(m_axis_tdata[3:0]));
        flag_field("code", want, want.code, m_axis_tdata[11:4]);
        flag_field("live", want, 8'(want.live), 8'(m_axis_tdata[12]));
        flag_field("live_count", want, 8'(want.live_count), 8'(m_axis_tdata[16:13]));
        flag_field("last", want, 8'(want.last), 8'(m_axis_tlast));
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, pending_slots.size());
      $display("fault_code_aging_table: mismatch");
      $finish;
    end
  end

  // Test sequence
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_hold();
    test_compaction();
    test_zero_hold();
    test_full_lists();
    test_min_hold();
    test_random_short_hold();
    test_random_any_hold();
    test_random_max_hold();
    drain_results();
    repeat (40) @(posedge clk);
    $display("Covered %0d reports and %0d slot results: hold times 12, 3, 0, 20, 1,",
             reports_sent, slots_checked);
    $display("random and 255, expiry with compaction, refresh, full-list drops, stalls.");
    if (errors == 0)
      $display("fault_code_aging_table: match");
    else
      $display("fault_code_aging_table: mismatch");
    $finish;
  end

endmodule
